@@ rtl/fcce_pkg.sv @@
`timescale 1ns / 1ps
package fcce_pkg;

    localparam int MAX_CLUSTERS = 4096;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_CLASSIFY = 3'd2,
        OP_NEXT     = 3'd3,
        OP_ALLOC    = 3'd4,
        OP_FREE     = 3'd5,
        OP_ATTACH   = 3'd6,
        OP_OFFSET   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        TY_AVAIL   = 3'd0,
        TY_RSVD    = 3'd1,
        TY_BAD     = 3'd2,
        TY_DATA    = 3'd3,
        TY_END     = 3'd4,
        TY_INVALID = 3'd5
    } etype_t;

    typedef enum logic [2:0] {
        CFG_FAT16     = 3'd0,
        CFG_COUNT     = 3'd1,
        CFG_ROOT      = 3'd2,
        CFG_DATA_AREA = 3'd3,
        CFG_CL_BYTES  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_FREE,
        ST_ATT2,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] cluster_index;
        logic [11:0] attach_cluster;
        logic [31:0] entry_value;
        logic        check_reserved;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] entry_out;
        logic [2:0]  entry_type;
        logic [11:0] cluster_out;
        logic [47:0] byte_offset;
    } rsp_t;

    localparam logic [31:0] END16 = 32'h0000_ffff;
    localparam logic [31:0] END32 = 32'h0fff_ffff;

    function automatic logic [31:0] mask_val(input logic f16, input logic [31:0] v);
        return f16 ? (v & END16) : (v & END32);
    endfunction

    function automatic logic [2:0] classify(input logic f16, input logic [31:0] v);
        logic [31:0] m;
        logic [31:0] bad;
        logic [31:0] dmax;
        logic [31:0] emin;
        m    = mask_val(f16, v);
        bad  = f16 ? 32'h0000_fff7 : 32'h0fff_fff7;
        dmax = f16 ? 32'h0000_fff6 : 32'h0fff_fff6;
        emin = f16 ? 32'h0000_fff8 : 32'h0fff_fff8;
        if (m == 32'd0)
            return TY_AVAIL;
        else if (m == 32'd1)
            return TY_RSVD;
        else if (m == bad)
            return TY_BAD;
        else if (m <= dmax)
            return TY_DATA;
        else if (m >= emin)
            return TY_END;
        else
            return TY_INVALID;
    endfunction

endpackage

@@ rtl/fcce_ram.sv @@
`timescale 1ns / 1ps
module fcce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fat_cluster_chain_engine.sv @@
`timescale 1ns / 1ps
// Cluster chain engine for a file allocation table held in one internal RAM.
// Channels: in (request, valid/ready), out (result, valid/ready), cfg
// (register index and data, valid/ready). Exactly one result per request.
// The table must be written (opcode write) before any entry is read.
// Read, write, classify, next, root offset and any request refused at EXEC go
// through EXEC and DONE; attach adds ATT2; byte offset adds MUL1 and MUL2 (12x21
// multiply split into two partial products). Allocate scans from cluster two,
// one RAM read per cycle; free chain walks one entry per cycle. Both are
// bounded by cluster_count.
// One request is in flight at a time; the RAM's single registered read port
// sets the pace. in_ready is high only when idle and the output register is
// free, so a new request is not taken until the last result has left.
// Reset clears the control state and the registers to their reset values
// (cluster_bytes 512); table contents are left as they are.
// When the receiver stalls, the result holds in the output register and no
// new request is taken until it leaves.
module fat_cluster_chain_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fcce_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fcce_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [47:0]   cfg_data
);

    localparam int AW = $clog2(fcce_pkg::MAX_CLUSTERS);
    localparam int CW = AW + 1;

    logic        fat16_reg;
    logic [12:0] count_reg;
    logic [47:0] root_reg;
    logic [47:0] area_reg;
    logic [20:0] cbytes_reg;

    fcce_pkg::state_t state_reg, state_next;
    fcce_pkg::req_t   req_reg, req_next;
    fcce_pkg::rsp_t   rsp_reg, rsp_next;
    logic             ovalid_reg, ovalid_next;
    logic             fwd_reg, fwd_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    steps_reg, steps_next;
    logic [11:0]      walk_ptr_reg, walk_ptr_next;
    logic [12:0]      walk_steps_reg, walk_steps_next;
    logic [47:0]      prod_lo_reg, prod_lo_next;
    logic [47:0]      prod_hi_reg, prod_hi_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    logic [CW-1:0] bnd;
    logic [31:0]   rval;
    logic [2:0]    rtype;
    logic [31:0]   endm;
    logic [31:0]   lnk;
    logic          ci_in_n, ci_data;

    fcce_ram #(.WIDTH(32), .DEPTH(fcce_pkg::MAX_CLUSTERS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign cfg_ready = (state_reg == fcce_pkg::ST_IDLE);
    assign in_ready  = (state_reg == fcce_pkg::ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat16_reg  <= 1'b0;
            count_reg  <= '0;
            root_reg   <= '0;
            area_reg   <= '0;
            cbytes_reg <= 21'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fcce_pkg::CFG_FAT16:     fat16_reg  <= cfg_data[0];
                fcce_pkg::CFG_COUNT:     count_reg  <= cfg_data[12:0];
                fcce_pkg::CFG_ROOT:      root_reg   <= cfg_data;
                fcce_pkg::CFG_DATA_AREA: area_reg   <= cfg_data;
                fcce_pkg::CFG_CL_BYTES:  cbytes_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if ({19'd0, count_reg} < 32'(fcce_pkg::MAX_CLUSTERS))
            bnd = CW'(count_reg);
        else
            bnd = CW'(fcce_pkg::MAX_CLUSTERS);
    end

    assign rval    = fat16_reg ? (rdata & fcce_pkg::END16) : rdata;
    assign rtype   = fcce_pkg::classify(fat16_reg, rval);
    assign endm    = fat16_reg ? fcce_pkg::END16 : fcce_pkg::END32;
    assign lnk     = fcce_pkg::mask_val(fat16_reg, rval);
    assign ci_in_n = {20'd0, req_reg.cluster_index} < 32'(bnd);
    assign ci_data = ci_in_n && (req_reg.cluster_index >= 12'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fcce_pkg::ST_IDLE;
            ovalid_reg     <= 1'b0;
            fwd_reg        <= 1'b0;
            walk_ptr_reg   <= '0;
            walk_steps_reg <= '0;
            cur_reg        <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ovalid_reg     <= ovalid_next;
            fwd_reg        <= fwd_next;
            walk_ptr_reg   <= walk_ptr_next;
            walk_steps_reg <= walk_steps_next;
            cur_reg        <= cur_next;
            steps_reg      <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
    end

    always_comb
    begin
        logic [CW-1:0] nxt_c;
        logic          more;
        logic [31:0]   ivec;
        logic [31:0]   fval;
        logic [2:0]    ftype;
        logic [31:0]   flnk;
        state_next      = state_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        ovalid_next     = ovalid_reg;
        fwd_next        = 1'b0;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        walk_ptr_next   = walk_ptr_reg;
        walk_steps_next = walk_steps_reg;
        prod_lo_next    = prod_lo_reg;
        prod_hi_next    = prod_hi_reg;
        we              = 1'b0;
        waddr           = req_reg.cluster_index[AW-1:0];
        wdata           = 32'd0;
        raddr           = req_reg.cluster_index[AW-1:0];
        nxt_c           = '0;
        more            = 1'b0;
        ivec            = 32'd0;
        fval            = 32'd0;
        ftype           = 3'd0;
        flnk            = 32'd0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            fcce_pkg::ST_IDLE:
            begin
                raddr = in_data.cluster_index[AW-1:0];
                if (in_valid && in_ready)
                begin
                    req_next   = in_data;
                    rsp_next   = '0;
                    cur_next   = CW'({20'd0, in_data.cluster_index});
                    steps_next = '0;
                    if (in_data.opcode == fcce_pkg::OP_ALLOC)
                    begin
                        cur_next = CW'(2);
                        raddr    = AW'(2);
                    end
                    state_next = fcce_pkg::ST_EXEC;
                end
            end
            fcce_pkg::ST_EXEC:
            begin
                state_next = fcce_pkg::ST_DONE;
                unique case (req_reg.opcode)
                    fcce_pkg::OP_READ:
                        if (!ci_in_n || (req_reg.check_reserved && !ci_data))
                            rsp_next.status = 1'b1;
                        else
                        begin
                            rsp_next.entry_out  = rval;
                            rsp_next.entry_type = rtype;
                        end
                    fcce_pkg::OP_WRITE:
                        if (!ci_data)
                            rsp_next.status = 1'b1;
                        else
                        begin
                            we    = 1'b1;
                            wdata = fat16_reg ? (req_reg.entry_value & fcce_pkg::END16)
                                              : req_reg.entry_value;
                        end
                    fcce_pkg::OP_CLASSIFY:
                    begin
                        rsp_next.entry_out  = req_reg.entry_value;
                        rsp_next.entry_type = fcce_pkg::classify(fat16_reg,
                                                                 req_reg.entry_value);
                    end
                    fcce_pkg::OP_NEXT:
                        if (!ci_in_n)
                            rsp_next.status = 1'b1;
                        else
                        begin
                            rsp_next.entry_out  = rval;
                            rsp_next.entry_type = rtype;
                            if (rtype == fcce_pkg::TY_DATA)
                                rsp_next.cluster_out = lnk[11:0];
                            else
                                rsp_next.status = 1'b1;
                        end
                    fcce_pkg::OP_ALLOC:
                    begin
                        // start the scan with the first candidate on rdata
                        raddr      = cur_reg[AW-1:0];
                        state_next = fcce_pkg::ST_SCAN;
                    end
                    fcce_pkg::OP_FREE:
                        state_next = fcce_pkg::ST_FREE;
                    fcce_pkg::OP_ATTACH:
                        if (!ci_data)
                            rsp_next.status = 1'b1;
                        else
                        begin
                            rsp_next.entry_type = rtype;
                            if (rtype != fcce_pkg::TY_END)
                                rsp_next.status = 1'b1;
                            else
                            begin
                                we    = 1'b1;
                                wdata = {20'd0, req_reg.attach_cluster};
                                state_next = fcce_pkg::ST_ATT2;
                            end
                        end
                    default:
                        if (req_reg.cluster_index == 12'd1)
                            rsp_next.byte_offset = root_reg;
                        else if (!ci_data)
                            rsp_next.status = 1'b1;
                        else
                        begin
                            prod_lo_next = 48'({24'd0, req_reg.cluster_index - 12'd2, 12'd0}
                                               >> 12);
                            state_next   = fcce_pkg::ST_MUL1;
                        end
                endcase
            end
            fcce_pkg::ST_SCAN:
            begin
                // cur_reg's entry is on rdata; prefetch next index
                raddr = AW'(cur_reg + CW'(1));
                if (cur_reg >= bnd)
                begin
                    rsp_next.status = 1'b1;
                    state_next      = fcce_pkg::ST_DONE;
                end
                else if (rtype == fcce_pkg::TY_AVAIL)
                begin
                    we    = 1'b1;
                    waddr = cur_reg[AW-1:0];
                    wdata = endm;
                    rsp_next.cluster_out = 12'(cur_reg);
                    state_next = fcce_pkg::ST_DONE;
                end
                else
                    cur_next = cur_reg + CW'(1);
            end
            fcce_pkg::ST_FREE:
            begin
                // a link back to the entry just cleared reads as zero
                fval  = fwd_reg ? 32'd0 : rval;
                ftype = fcce_pkg::classify(fat16_reg, fval);
                flnk  = fcce_pkg::mask_val(fat16_reg, fval);
                ivec  = 32'(cur_reg);
                if (cur_reg < bnd && ftype == fcce_pkg::TY_DATA)
                begin
                    more  = flnk != 32'd0;
                end
                if (flnk < 32'(bnd))
                    nxt_c = CW'(flnk);
                if (cur_reg >= CW'(2) && cur_reg < bnd)
                begin
                    we    = 1'b1;
                    waddr = cur_reg[AW-1:0];
                    wdata = 32'd0;
                end
                walk_ptr_next = ivec[11:0];
                steps_next    = steps_reg + CW'(1);
                raddr         = nxt_c[AW-1:0];
                fwd_next      = we && (nxt_c[AW-1:0] == cur_reg[AW-1:0]);
                if (!more || flnk >= 32'(bnd) || (steps_reg + CW'(1)) >= bnd)
                begin
                    walk_steps_next = 13'(steps_reg + CW'(1));
                    state_next      = fcce_pkg::ST_DONE;
                end
                else
                    cur_next = nxt_c;
            end
            fcce_pkg::ST_ATT2:
            begin
                if ({20'd0, req_reg.attach_cluster} < 32'(bnd)
                    && req_reg.attach_cluster >= 12'd2)
                begin
                    we    = 1'b1;
                    waddr = req_reg.attach_cluster[AW-1:0];
                    wdata = endm;
                end
                else
                    rsp_next.status = 1'b1;
                state_next = fcce_pkg::ST_DONE;
            end
            fcce_pkg::ST_MUL1:
            begin
                // split 12x21 into two narrower partial products
                prod_hi_next = 48'(prod_lo_reg[11:0] * cbytes_reg[20:10]);
                prod_lo_next = 48'(prod_lo_reg[11:0] * cbytes_reg[9:0]);
                state_next   = fcce_pkg::ST_MUL2;
            end
            fcce_pkg::ST_MUL2:
            begin
                rsp_next.byte_offset = area_reg + (prod_hi_reg << 10) + prod_lo_reg;
                state_next           = fcce_pkg::ST_DONE;
            end
            fcce_pkg::ST_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = fcce_pkg::ST_IDLE;
            end
            default:
                state_next = fcce_pkg::ST_IDLE;
        endcase
    end

endmodule
